[rtl/cda_pkg.sv]
// Shared types and constants for the calendar date adder.
// Request/response structs, command codes, sequencer states, month-length lookup.
// No dependencies.
package cda_pkg;

   localparam int unsigned YEAR_BITS_DEF   = 16;
   localparam int unsigned AMOUNT_BITS_DEF = 16;

   // date after reset: March 15, 2015
   localparam int unsigned RESET_YEAR        = 2015;
   localparam logic [3:0]  RESET_MONTH       = 4'd3;
   localparam logic [4:0]  RESET_DAY         = 5'd15;
   localparam logic [4:0]  RESET_YEAR_MOD25  = 5'd15;

   localparam logic [3:0]  MONTH_FIRST       = 4'd1;
   localparam logic [3:0]  MONTH_LAST        = 4'd12;
   localparam logic [4:0]  DIVISOR_MONTHS    = 5'd12;
   localparam logic [4:0]  DIVISOR_LEAP      = 5'd25;
   localparam logic [4:0]  FEB_LEAP_DAYS     = 5'd29;

   typedef enum logic [1:0] {
      CMD_LOAD       = 2'd0,
      CMD_ADD_DAYS   = 2'd1,
      CMD_ADD_MONTHS = 2'd2,
      CMD_ADD_YEARS  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAYS,
      ST_DIV_MONTH,
      ST_MONTH_REM,
      ST_YEAR_ADD,
      ST_DIV_YEAR,
      ST_MOD_YEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [15:0] amount;
   } req_type;

   typedef struct packed {
      logic [15:0] cur_year;
      logic [3:0]  cur_month;
      logic [4:0]  cur_day;
   } rsp_type;

   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd2:                      len = leap ? FEB_LEAP_DAYS : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[rtl/calendar_date_adder.sv]
// Gregorian date register with load / add days / add months / add years commands.
// One request in flight; every request answers with the date after the command.
// Depends on cda_pkg.
//
// The block accepts a request only while its sequencer is idle and answers each with one
// response. The response is registered as the sequencer returns to idle, so the next request
// can be taken while it is presented. A response still held by rsp_stall makes the next request
// wait in ST_DONE, so input stays stalled meanwhile. Add days walks one month per cycle with a
// compare-and-subtract against the month length; the other commands share one reciprocal
// multiplier for the division by 12 (month carry) and by 25 (year mod 25, which together with
// the low year bits gives the leap rule). The year saturates at 2^YEAR_BITS-1 and is presented
// as its low 16 bits.
module calendar_date_adder #(
   parameter int unsigned YEAR_BITS   = cda_pkg::YEAR_BITS_DEF,
   parameter int unsigned AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cda_pkg::rsp_type rsp_data
);

   localparam int unsigned DIV_BITS = (YEAR_BITS > AMOUNT_BITS + 1) ? YEAR_BITS : AMOUNT_BITS + 1;
   localparam int unsigned SUM_BITS = DIV_BITS + 1;
   localparam int unsigned D_BITS   = AMOUNT_BITS + 1;
   localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

   // x / d == (x * ceil(2^SHIFT / d)) >> SHIFT, exact for x < 2^DIV_BITS and d < 32
   localparam int unsigned SHIFT     = DIV_BITS + 5;
   localparam int unsigned RCP_BITS  = DIV_BITS + 2;
   localparam int unsigned PROD_BITS = DIV_BITS + RCP_BITS;
   localparam logic [RCP_BITS-1:0] RCP_MONTHS = RCP_BITS'(((64'd1 << SHIFT)
      + 64'(cda_pkg::DIVISOR_MONTHS) - 64'd1) / 64'(cda_pkg::DIVISOR_MONTHS));
   localparam logic [RCP_BITS-1:0] RCP_LEAP   = RCP_BITS'(((64'd1 << SHIFT)
      + 64'(cda_pkg::DIVISOR_LEAP) - 64'd1) / 64'(cda_pkg::DIVISOR_LEAP));

   cda_pkg::state_type     state_ff, state_in;
   logic [YEAR_BITS-1:0]   year_ff, year_in;
   logic [3:0]             month_ff, month_in;
   logic [4:0]             day_ff, day_in;
   logic [4:0]             mod25_ff, mod25_in;
   logic [D_BITS-1:0]      dcount_ff, dcount_in;
   logic [DIV_BITS-1:0]    div_ff, div_in;
   logic [DIV_BITS-1:0]    quot_ff, quot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   cda_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   // shared reciprocal multiplier
   logic [RCP_BITS-1:0]    mul_recip;
   logic [PROD_BITS-1:0]   mul_product;
   logic [DIV_BITS-1:0]    mul_quot;
   logic [4:0]             divisor;
   logic [4:0]             rem_low;

   // date arithmetic
   logic                   leap;
   logic [4:0]             month_len;
   logic                   day_fits;
   logic [YEAR_BITS-1:0]   year_inc;
   logic [4:0]             mod25_inc;
   logic [SUM_BITS-1:0]    year_sum;
   logic [YEAR_BITS-1:0]   year_sat;
   logic [3:0]             load_month_clamped;

   assign mul_recip   = (state_ff == cda_pkg::ST_DIV_MONTH) ? RCP_MONTHS : RCP_LEAP;
   assign mul_product = PROD_BITS'(div_ff) * PROD_BITS'(mul_recip);
   assign mul_quot    = DIV_BITS'(mul_product[PROD_BITS-1:SHIFT]);

   // remainder is below 32, so the low five bits of x - q*d are exact
   assign divisor     = (state_ff == cda_pkg::ST_MONTH_REM) ? cda_pkg::DIVISOR_MONTHS
                                                            : cda_pkg::DIVISOR_LEAP;
   assign rem_low     = div_ff[4:0] - 5'(quot_ff[4:0] * divisor);

   // y%100==0 <=> y%4==0 && y%25==0 ; y%400==0 <=> y%16==0 && y%25==0
   assign leap      = ((year_ff[1:0] == 2'd0) && (mod25_ff != 5'd0))
                   || ((year_ff[3:0] == 4'd0) && (mod25_ff == 5'd0));
   assign month_len = cda_pkg::days_in_month(month_ff, leap);
   assign day_fits  = dcount_ff <= D_BITS'(month_len);

   assign year_inc  = (year_ff == YEAR_MAX) ? year_ff : year_ff + 1'b1;
   assign mod25_inc = (year_ff == YEAR_MAX) ? mod25_ff
                    : ((mod25_ff == cda_pkg::DIVISOR_LEAP - 5'd1) ? 5'd0 : mod25_ff + 5'd1);

   assign year_sum  = {1'b0, DIV_BITS'(year_ff)} + {1'b0, quot_ff};
   assign year_sat  = (|year_sum[SUM_BITS-1:YEAR_BITS]) ? YEAR_MAX : year_sum[YEAR_BITS-1:0];

   always_comb begin
      if (req_data.load_month == 4'd0) begin
         load_month_clamped = cda_pkg::MONTH_FIRST;
      end else if (req_data.load_month > cda_pkg::MONTH_LAST) begin
         load_month_clamped = cda_pkg::MONTH_LAST;
      end else begin
         load_month_clamped = req_data.load_month;
      end
   end

   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      mod25_in     = mod25_ff;
      dcount_in    = dcount_ff;
      div_in       = div_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         cda_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.cmd)
                  cda_pkg::CMD_LOAD: begin
                     year_in  = YEAR_BITS'(req_data.load_year);
                     month_in = load_month_clamped;
                     day_in   = req_data.load_day;
                     div_in   = DIV_BITS'(YEAR_BITS'(req_data.load_year));
                     state_in = cda_pkg::ST_DIV_YEAR;
                  end
                  cda_pkg::CMD_ADD_DAYS: begin
                     dcount_in = D_BITS'(day_ff) + D_BITS'(AMOUNT_BITS'(req_data.amount));
                     state_in  = cda_pkg::ST_DAYS;
                  end
                  cda_pkg::CMD_ADD_MONTHS: begin
                     div_in   = DIV_BITS'(month_ff - 4'd1)
                              + DIV_BITS'(AMOUNT_BITS'(req_data.amount));
                     state_in = cda_pkg::ST_DIV_MONTH;
                  end
                  cda_pkg::CMD_ADD_YEARS: begin
                     quot_in  = DIV_BITS'(AMOUNT_BITS'(req_data.amount));
                     state_in = cda_pkg::ST_YEAR_ADD;
                  end
               endcase
            end
         end
         cda_pkg::ST_DAYS: begin
            if (day_fits) begin
               day_in   = dcount_ff[4:0];
               state_in = cda_pkg::ST_DONE;
            end else begin
               dcount_in = dcount_ff - D_BITS'(month_len);
               if (month_ff >= cda_pkg::MONTH_LAST) begin
                  month_in = cda_pkg::MONTH_FIRST;
                  year_in  = year_inc;
                  mod25_in = mod25_inc;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end
         cda_pkg::ST_DIV_MONTH: begin
            quot_in  = mul_quot;
            state_in = cda_pkg::ST_MONTH_REM;
         end
         cda_pkg::ST_MONTH_REM: begin
            // remainder is the new zero-based month, quotient carries into the year
            month_in = rem_low[3:0] + 4'd1;
            state_in = cda_pkg::ST_YEAR_ADD;
         end
         cda_pkg::ST_YEAR_ADD: begin
            year_in  = year_sat;
            div_in   = DIV_BITS'(year_sat);
            state_in = cda_pkg::ST_DIV_YEAR;
         end
         cda_pkg::ST_DIV_YEAR: begin
            quot_in  = mul_quot;
            state_in = cda_pkg::ST_MOD_YEAR;
         end
         cda_pkg::ST_MOD_YEAR: begin
            mod25_in = rem_low;
            state_in = cda_pkg::ST_DONE;
         end
         cda_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.cur_year  = 16'(year_ff);
               rsp_data_in.cur_month = month_ff;
               rsp_data_in.cur_day   = day_ff;
               state_in              = cda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cda_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cda_pkg::ST_IDLE;
         year_ff      <= YEAR_BITS'(cda_pkg::RESET_YEAR);
         month_ff     <= cda_pkg::RESET_MONTH;
         day_ff       <= cda_pkg::RESET_DAY;
         mod25_ff     <= cda_pkg::RESET_YEAR_MOD25;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         mod25_ff     <= mod25_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dcount_ff   <= dcount_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != cda_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      month_ff >= cda_pkg::MONTH_FIRST && month_ff <= cda_pkg::MONTH_LAST)
      else $error("stored month out of range");

   a_mod25_range: assert property (@(posedge clock) disable iff (reset)
      mod25_ff < cda_pkg::DIVISOR_LEAP)
      else $error("year mod 25 tracker out of range");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != cda_pkg::ST_IDLE)
      else $error("accepted request did not start the sequencer");

   a_done_response: assert property (@(posedge clock) disable iff (reset)
      state_ff == cda_pkg::ST_DONE && !rsp_stall |=> rsp_valid_ff)
      else $error("finished request produced no response");

endmodule

[verif/calendar_date_adder_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for calendar_date_adder: directed and random date commands.
// Predicts each response date in the bench and compares field by field; uses cda_pkg.
module calendar_date_adder_tb;

   localparam int unsigned YEAR_MAX  = (1 << cda_pkg::YEAR_BITS_DEF) - 1;
   localparam int unsigned HOLD_LEN  = 500;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cda_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cda_pkg::rsp_type rsp_data;

   // predicted date register
   int unsigned date_year  = cda_pkg::RESET_YEAR;
   int unsigned date_month = 32'(cda_pkg::RESET_MONTH);
   int unsigned date_day   = 32'(cda_pkg::RESET_DAY);

   cda_pkg::rsp_type pending_dates[$];
   int unsigned error_count = 0;
   int unsigned burst_left = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned phase_left = 0;
   int unsigned tick = 0;
   stall_style_type stall_style = STALL_NONE;

   calendar_date_adder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned year_plus(input int unsigned y, input int unsigned n);
      return (y + n > YEAR_MAX) ? YEAR_MAX : y + n;
   endfunction

   function automatic cda_pkg::req_type random_request();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(cda_pkg::req_type)-1:0];
   endfunction

   // applies one command to the predicted date and returns the expected response
   function automatic cda_pkg::rsp_type advance_date(input cda_pkg::req_type r);
      int unsigned d;
      int unsigned len;
      int unsigned total;
      bit rolling;
      logic leap;
      cda_pkg::rsp_type res;
      case (r.cmd)
         cda_pkg::CMD_LOAD: begin
            if (r.load_month == 4'd0)
               date_month = 1;
            else if (r.load_month > 4'd12)
               date_month = 12;
            else
               date_month = 32'(r.load_month);
            date_year = 32'(r.load_year);
            date_day  = 32'(r.load_day);
         end
         cda_pkg::CMD_ADD_DAYS: begin
            d = date_day + 32'(r.amount);
            rolling = 1'b1;
            while (rolling) begin
               leap = ((date_year % 4 == 0) && (date_year % 100 != 0)) ||
                      (date_year % 400 == 0);
               case (date_month)
                  2:           len = leap ? 29 : 28;
                  4, 6, 9, 11: len = 30;
                  default:     len = 31;
               endcase
               if (d <= len) begin
                  rolling = 1'b0;
               end else begin
                  d -= len;
                  if (date_month >= 12) begin
                     date_month = 1;
                     date_year  = year_plus(date_year, 1);
                  end else begin
                     date_month++;
                  end
               end
            end
            date_day = d;
         end
         cda_pkg::CMD_ADD_MONTHS: begin
            total      = date_month - 1 + 32'(r.amount);
            date_year  = year_plus(date_year, total / 12);
            date_month = total % 12 + 1;
         end
         cda_pkg::CMD_ADD_YEARS: begin
            date_year = year_plus(date_year, 32'(r.amount));
         end
      endcase
      res.cur_year  = date_year[15:0];
      res.cur_month = date_month[3:0];
      res.cur_day   = date_day[4:0];
      return res;
   endfunction

   // sender idles between bursts of random length
   task automatic send_request(input cda_pkg::req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_data  <= random_request();
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_dates.push_back(advance_date(r));
   endtask

   task automatic load_date(input int unsigned y, input int unsigned m, input int unsigned d);
      cda_pkg::req_type r;
      r.cmd        = cda_pkg::CMD_LOAD;
      r.load_year  = y[15:0];
      r.load_month = m[3:0];
      r.load_day   = d[4:0];
      r.amount     = 16'($urandom);
      send_request(r);
   endtask

   // unused load fields carry random bits
   task automatic add_amount(input cda_pkg::cmd_type c, input int unsigned n);
      cda_pkg::req_type r;
      r            = random_request();
      r.cmd        = c;
      r.amount     = n[15:0];
      send_request(r);
   endtask

   function automatic int unsigned random_amount();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 60);
         6, 7:             return $urandom_range(0, 1500);
         8:                return $urandom_range(0, 65535);
         default:          return $urandom_range(65000, 65535);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      cda_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("unexpected response, year", 32'(rsp_data.cur_year), 0);
         end else begin
            want = pending_dates.pop_front();
            if (rsp_data.cur_year != want.cur_year)
               report_mismatch("year", 32'(rsp_data.cur_year), 32'(want.cur_year));
            if (rsp_data.cur_month != want.cur_month)
               report_mismatch("month", 32'(rsp_data.cur_month), 32'(want.cur_month));
            if (rsp_data.cur_day != want.cur_day)
               report_mismatch("day", 32'(rsp_data.cur_day), 32'(want.cur_day));
         end
      end
   end

   // receiver: changing stall styles, plus long hold-offs on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_LEN;
         end
         if (phase_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            phase_left  = $urandom_range(20, 120);
         end
         phase_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_PERIODIC: rsp_stall <= (tick % 7 < 3);
               STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic test_reset_date();
      add_amount(cda_pkg::CMD_ADD_DAYS, 0);
   endtask

   task automatic test_leap_rule();
      load_date(2024, 2, 28);
      add_amount(cda_pkg::CMD_ADD_DAYS, 1);
      add_amount(cda_pkg::CMD_ADD_DAYS, 1);
      load_date(1900, 2, 28);
      add_amount(cda_pkg::CMD_ADD_DAYS, 1);
      load_date(2000, 2, 29);
      add_amount(cda_pkg::CMD_ADD_DAYS, 0);
      load_date(2023, 12, 31);
      add_amount(cda_pkg::CMD_ADD_DAYS, 1);
   endtask

   task automatic test_load_clamping();
      load_date(2021, 0, 10);
      load_date(2021, 13, 5);
      load_date(2021, 15, 31);
   endtask

   // day zero and days past the month end are kept until days are added
   task automatic test_unclamped_days();
      load_date(2023, 2, 31);
      add_amount(cda_pkg::CMD_ADD_DAYS, 0);
      load_date(2021, 1, 31);
      add_amount(cda_pkg::CMD_ADD_MONTHS, 1);
      load_date(2021, 4, 0);
      add_amount(cda_pkg::CMD_ADD_MONTHS, 2);
      add_amount(cda_pkg::CMD_ADD_YEARS, 3);
      add_amount(cda_pkg::CMD_ADD_DAYS, 0);
      add_amount(cda_pkg::CMD_ADD_DAYS, 1);
   endtask

   task automatic test_year_saturation();
      load_date(65535, 12, 31);
      add_amount(cda_pkg::CMD_ADD_DAYS, 1);
      load_date(0, 1, 1);
      add_amount(cda_pkg::CMD_ADD_YEARS, 65535);
      load_date(65530, 12, 1);
      add_amount(cda_pkg::CMD_ADD_MONTHS, 65535);
      load_date(0, 3, 1);
      add_amount(cda_pkg::CMD_ADD_DAYS, 65535);
   endtask

   // response side held off while requests keep coming, so the input backs up
   task automatic test_backpressure();
      int unsigned i;
      hold_requests++;
      for (i = 0; i < 8; i++)
         add_amount(cda_pkg::cmd_type'($urandom_range(1, 3)), $urandom_range(0, 400));
   endtask

   task automatic test_random_traffic();
      int unsigned i;
      int unsigned pick;
      int unsigned y;
      int unsigned m;
      int unsigned d;
      for (i = 0; i < 232; i++) begin
         if (i % 90 == 45)
            hold_requests++;
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: y = $urandom_range(1800, 2500);
               5, 6:          y = $urandom_range(0, 65535);
               7:             y = $urandom_range(65500, 65535);
               8:             y = 100 * $urandom_range(0, 655);
               default:       y = $urandom_range(0, 50);
            endcase
            if ($urandom_range(0, 9) == 0) begin
               m = $urandom_range(0, 15);
               d = $urandom_range(0, 31);
            end else begin
               m = $urandom_range(1, 12);
               d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28);
            end
            load_date(y, m, d);
         end else if (pick < 55) begin
            add_amount(cda_pkg::CMD_ADD_DAYS, random_amount());
         end else if (pick < 80) begin
            add_amount(cda_pkg::CMD_ADD_MONTHS, random_amount());
         end else begin
            add_amount(cda_pkg::CMD_ADD_YEARS,
                       ($urandom_range(0, 7) == 0) ? random_amount() : $urandom_range(0, 30));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_date();
      test_leap_rule();
      test_load_clamping();
      test_unclamped_days();
      test_year_saturation();
      test_backpressure();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
